// File: design/hsi2rgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSI to RGB package
// Shared constants, codes and the cosine ratio table builder used by the
// hue converter pipeline.
// ----------------------------------------------------------------------------
package hsi2rgb_pkg;

  // Default widths for the top level parameters.
  localparam int unsigned CHANNEL_BITS_DEF = 8;
  localparam int unsigned RATIO_FRAC_DEF   = 12;

  // Hue and configuration formats.
  localparam int unsigned HUE_W         = 9;
  localparam int unsigned CFG_W         = 9;
  localparam int unsigned CFG_ADDR_W    = 2;
  localparam int unsigned CFG_FRAC_BITS = 8;
  localparam logic [CFG_W-1:0] UNIT_Q8  = 9'd256;

  // Hue geometry.
  localparam logic [HUE_W-1:0] HUE_WRAP   = 9'd360;
  localparam int unsigned      SECTOR_DEG = 120;
  localparam int unsigned      OFF_W      = $clog2(SECTOR_DEG);
  localparam logic [HUE_W-1:0] SECTOR1_START = 9'd120;
  localparam logic [HUE_W-1:0] SECTOR2_START = 9'd240;

  // Rotation constants for the cosine table, Q2.30.
  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint COS_ONE_DEG = 64'sd1073578288;
  localparam longint SIN_ONE_DEG = 64'sd18739379;
  localparam int unsigned RATIO_PIVOT = 60;

  // Which channel takes the primary role.
  typedef enum logic [1:0] {
    SECTOR_RED   = 2'd0,
    SECTOR_GREEN = 2'd1,
    SECTOR_BLUE  = 2'd2
  } sector_e;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SATURATION = 2'd0,
    CFG_INTENSITY  = 2'd1,
    CFG_INVERT     = 2'd2
  } cfg_idx_e;

  // One entry of cos(d)/cos(|60-d|) with frac_bits fraction bits. The cosines
  // come from repeated one-degree rotations, truncated toward zero at each step.
  // Only evaluated at elaboration to build a constant table.
  function automatic longint ratio_entry(input int unsigned d,
                                         input int unsigned frac_bits);
    longint      cosv [SECTOR_DEG];
    longint      x;
    longint      y;
    longint      nx;
    longint      ny;
    longint      num;
    longint      den;
    longint      mag;
    longint      quo;
    longint      rem;
    logic        neg;
    int unsigned m;
    x       = Q30_ONE;
    y       = 64'sd0;
    cosv[0] = x;
    for (int k = 1; k < SECTOR_DEG; k++) begin
      nx      = (COS_ONE_DEG * x - SIN_ONE_DEG * y) / Q30_ONE;
      ny      = (SIN_ONE_DEG * x + COS_ONE_DEG * y) / Q30_ONE;
      x       = nx;
      y       = ny;
      cosv[k] = x;
    end
    m   = (d <= RATIO_PIVOT) ? (RATIO_PIVOT - d) : (d - RATIO_PIVOT);
    den = cosv[m];
    num = cosv[d] * (longint'(1) << frac_bits);
    if (den <= 0) return 64'sd0;
    // Restoring long division of the magnitude, truncated toward zero.
    neg = (num < 0);
    mag = neg ? -num : num;
    quo = 64'sd0;
    rem = 64'sd0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((mag >>> b) & 64'sd1);
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | (longint'(1) << b);
      end
    end
    return neg ? -quo : quo;
  endfunction

endpackage

// File: design/hsi2rgb_sector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSI to RGB sector stage
// Folds the hue into one turn, picks the 120-degree sector and looks up the
// cosine ratio for the offset inside it. Two register stages.
// ----------------------------------------------------------------------------
module hsi2rgb_sector #(
  parameter int unsigned RATIO_FRACTION_BITS = hsi2rgb_pkg::RATIO_FRAC_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [hsi2rgb_pkg::HUE_W-1:0]        hue_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output hsi2rgb_pkg::sector_e                 sector_o,
  output logic signed [RATIO_FRACTION_BITS+2:0] ratio_o
);
  import hsi2rgb_pkg::*;

  localparam int unsigned RW = RATIO_FRACTION_BITS + 3;

  // Constant ratio table.
  logic signed [RW-1:0] ratio_tab [SECTOR_DEG];

  for (genvar k = 0; k < SECTOR_DEG; k++) begin : g_tab
    assign ratio_tab[k] = RW'(ratio_entry(k, RATIO_FRACTION_BITS));
  end

  logic                 a_valid_q, a_valid_d;
  sector_e              a_sector_q, a_sector_d;
  logic [OFF_W-1:0]     a_off_q, a_off_d;
  logic                 b_valid_q, b_valid_d;
  sector_e              b_sector_q;
  logic signed [RW-1:0] b_ratio_q;
  logic                 a_ready;
  logic                 b_ready;
  logic [HUE_W-1:0]     hue_fold;
  logic [HUE_W-1:0]     off_full;

  // Each stage moves when it is empty or its successor takes its item.
  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  // Fold one turn, then split into sectors.
  always_comb begin
    hue_fold = (hue_i >= HUE_WRAP) ? (hue_i - HUE_WRAP) : hue_i;
    if (hue_fold >= SECTOR2_START) begin
      a_sector_d = SECTOR_BLUE;
      off_full   = hue_fold - SECTOR2_START;
    end else if (hue_fold >= SECTOR1_START) begin
      a_sector_d = SECTOR_GREEN;
      off_full   = hue_fold - SECTOR1_START;
    end else begin
      a_sector_d = SECTOR_RED;
      off_full   = hue_fold;
    end
    a_off_d = off_full[OFF_W-1:0];
  end

  assign a_valid_d = a_ready ? in_valid_i : a_valid_q;
  assign b_valid_d = b_ready ? a_valid_q : b_valid_q;

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_sector_q <= a_sector_d;
      a_off_q    <= a_off_d;
    end
    if (b_ready && a_valid_q) begin
      b_sector_q <= a_sector_q;
      b_ratio_q  <= ratio_tab[a_off_q];
    end
  end

  assign out_valid_o = b_valid_q;
  assign sector_o    = b_sector_q;
  assign ratio_o     = b_ratio_q;

endmodule

// File: design/hsi2rgb_terms.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSI to RGB term stage
// Forms the primary, secondary and third channel terms from saturation and
// the cosine ratio, then scales them by intensity. Two register stages.
// ----------------------------------------------------------------------------
module hsi2rgb_terms #(
  parameter int unsigned RATIO_FRACTION_BITS = hsi2rgb_pkg::RATIO_FRAC_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [hsi2rgb_pkg::CFG_W-1:0]         saturation_i,
  input  logic [hsi2rgb_pkg::CFG_W-1:0]         intensity_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  hsi2rgb_pkg::sector_e                  sector_i,
  input  logic signed [RATIO_FRACTION_BITS+2:0] ratio_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output hsi2rgb_pkg::sector_e                  sector_o,
  output logic [RATIO_FRACTION_BITS+18:0]       prim_o,
  output logic [RATIO_FRACTION_BITS+18:0]       sec_o,
  output logic [RATIO_FRACTION_BITS+18:0]       ter_o
);
  import hsi2rgb_pkg::*;

  localparam int unsigned R      = RATIO_FRACTION_BITS;
  localparam int unsigned RW     = R + 3;
  localparam int unsigned MUL_W  = CFG_W + 1 + RW;
  localparam int unsigned PROD_W = R + CFG_W + 2;
  localparam int unsigned TERM_W = R + CFG_W + 1;
  localparam int unsigned PW     = TERM_W + CFG_W;

  localparam logic signed [RW-1:0]   ONE  = RW'(longint'(1) << R);
  localparam logic signed [PROD_W:0] BASE =
    (PROD_W + 1)'(longint'(UNIT_Q8) << R);

  logic                     c_valid_q, c_valid_d;
  sector_e                  c_sector_q;
  logic signed [PROD_W-1:0] c_sp_q;
  logic signed [PROD_W-1:0] c_ss_q;
  logic                     d_valid_q, d_valid_d;
  sector_e                  d_sector_q;
  logic [PW-1:0]            d_prim_q, d_prim_d;
  logic [PW-1:0]            d_sec_q, d_sec_d;
  logic [PW-1:0]            d_ter_q, d_ter_d;
  logic                     c_ready;
  logic                     d_ready;

  logic signed [CFG_W:0]    sat_s;
  logic signed [RW-1:0]     one_minus;
  logic signed [MUL_W-1:0]  sp_full;
  logic signed [MUL_W-1:0]  ss_full;
  logic signed [PROD_W:0]   prim_term;
  logic signed [PROD_W:0]   sec_term;
  logic [TERM_W-1:0]        prim_u;
  logic [TERM_W-1:0]        sec_u;
  logic [TERM_W-1:0]        ter_u;
  logic [CFG_W-1:0]         sat_rest;

  assign d_ready    = !d_valid_q || out_ready_i;
  assign c_ready    = !c_valid_q || d_ready;
  assign in_ready_o = c_ready;

  // Saturation times ratio and times one minus ratio.
  always_comb begin
    sat_s     = $signed({1'b0, saturation_i});
    one_minus = ONE - ratio_i;
    sp_full   = sat_s * ratio_i;
    ss_full   = sat_s * one_minus;
  end

  // Add the unit term, drop negatives, scale by intensity.
  always_comb begin
    prim_term = BASE + {c_sp_q[PROD_W-1], c_sp_q};
    sec_term  = BASE + {c_ss_q[PROD_W-1], c_ss_q};
    prim_u    = prim_term[PROD_W] ? '0 : prim_term[TERM_W-1:0];
    sec_u     = sec_term[PROD_W] ? '0 : sec_term[TERM_W-1:0];
    sat_rest  = UNIT_Q8 - saturation_i;
    ter_u     = TERM_W'(sat_rest) << R;
    d_prim_d  = PW'(prim_u) * PW'(intensity_i);
    d_sec_d   = PW'(sec_u) * PW'(intensity_i);
    d_ter_d   = PW'(ter_u) * PW'(intensity_i);
  end

  assign c_valid_d = c_ready ? in_valid_i : c_valid_q;
  assign d_valid_d = d_ready ? c_valid_q : d_valid_q;

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      c_valid_q <= c_valid_d;
      d_valid_q <= d_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (c_ready && in_valid_i) begin
      c_sector_q <= sector_i;
      c_sp_q     <= sp_full[PROD_W-1:0];
      c_ss_q     <= ss_full[PROD_W-1:0];
    end
    if (d_ready && c_valid_q) begin
      d_sector_q <= c_sector_q;
      d_prim_q   <= d_prim_d;
      d_sec_q    <= d_sec_d;
      d_ter_q    <= d_ter_d;
    end
  end

  assign out_valid_o = d_valid_q;
  assign sector_o    = d_sector_q;
  assign prim_o      = d_prim_q;
  assign sec_o       = d_sec_q;
  assign ter_o       = d_ter_q;

endmodule

// File: design/hsi2rgb_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSI to RGB output stage
// Multiplies by full scale, drops the fraction, divides by three, saturates,
// optionally inverts and routes the roles to red, green and blue.
// ----------------------------------------------------------------------------
module hsi2rgb_scale #(
  parameter int unsigned CHANNEL_BITS        = hsi2rgb_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned RATIO_FRACTION_BITS = hsi2rgb_pkg::RATIO_FRAC_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            invert_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  hsi2rgb_pkg::sector_e            sector_i,
  input  logic [RATIO_FRACTION_BITS+18:0] prim_i,
  input  logic [RATIO_FRACTION_BITS+18:0] sec_i,
  input  logic [RATIO_FRACTION_BITS+18:0] ter_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [CHANNEL_BITS-1:0]         red_o,
  output logic [CHANNEL_BITS-1:0]         green_o,
  output logic [CHANNEL_BITS-1:0]         blue_o
);
  import hsi2rgb_pkg::*;

  localparam int unsigned CB     = CHANNEL_BITS;
  localparam int unsigned PW     = RATIO_FRACTION_BITS + 2 * CFG_W + 1;
  localparam int unsigned YW     = PW + CB;
  localparam int unsigned SHIFT  = 2 * CFG_FRAC_BITS + RATIO_FRACTION_BITS;
  localparam int unsigned QW     = CB + 2;
  localparam int unsigned DIV_S  = QW + 1;
  localparam logic [DIV_S-1:0] DIV_M =
    DIV_S'(((longint'(1) << DIV_S) + 2) / 3);
  localparam logic [QW-1:0] FULL_Q = QW'((longint'(1) << CB) - 1);

  logic            e_valid_q, e_valid_d;
  sector_e         e_sector_q;
  logic [QW-1:0]   e_prim_q;
  logic [QW-1:0]   e_sec_q;
  logic [QW-1:0]   e_ter_q;
  logic            f_valid_q, f_valid_d;
  logic [CB-1:0]   f_red_q, f_red_d;
  logic [CB-1:0]   f_green_q, f_green_d;
  logic [CB-1:0]   f_blue_q, f_blue_d;
  logic            e_ready;
  logic            f_ready;
  logic [YW-1:0]   y_prim;
  logic [YW-1:0]   y_sec;
  logic [YW-1:0]   y_ter;
  logic [CB-1:0]   v_prim;
  logic [CB-1:0]   v_sec;
  logic [CB-1:0]   v_ter;

  // Division by three through a reciprocal, then saturate and invert.
  function automatic logic [CB-1:0] finish(input logic [QW-1:0] n, input logic inv);
    logic [QW+DIV_S-1:0] prod;
    logic [QW-1:0]       quot;
    logic [CB-1:0]       v;
    prod = (QW + DIV_S)'(n) * (QW + DIV_S)'(DIV_M);
    quot = prod[DIV_S +: QW];
    v    = (quot > FULL_Q) ? FULL_Q[CB-1:0] : quot[CB-1:0];
    return inv ? ~v : v;
  endfunction

  assign f_ready    = !f_valid_q || out_ready_i;
  assign e_ready    = !e_valid_q || f_ready;
  assign in_ready_o = e_ready;

  // Times full scale as a shift and subtract.
  always_comb begin
    y_prim = (YW'(prim_i) << CB) - YW'(prim_i);
    y_sec  = (YW'(sec_i) << CB) - YW'(sec_i);
    y_ter  = (YW'(ter_i) << CB) - YW'(ter_i);
  end

  // Route the roles to the color channels.
  always_comb begin
    v_prim = finish(e_prim_q, invert_i);
    v_sec  = finish(e_sec_q, invert_i);
    v_ter  = finish(e_ter_q, invert_i);
    unique case (e_sector_q)
      SECTOR_RED: begin
        f_red_d   = v_prim;
        f_green_d = v_sec;
        f_blue_d  = v_ter;
      end
      SECTOR_GREEN: begin
        f_green_d = v_prim;
        f_blue_d  = v_sec;
        f_red_d   = v_ter;
      end
      default: begin
        f_blue_d  = v_prim;
        f_red_d   = v_sec;
        f_green_d = v_ter;
      end
    endcase
  end

  assign e_valid_d = e_ready ? in_valid_i : e_valid_q;
  assign f_valid_d = f_ready ? e_valid_q : f_valid_q;

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
    end else begin
      e_valid_q <= e_valid_d;
      f_valid_q <= f_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (e_ready && in_valid_i) begin
      e_sector_q <= sector_i;
      e_prim_q   <= y_prim[SHIFT +: QW];
      e_sec_q    <= y_sec[SHIFT +: QW];
      e_ter_q    <= y_ter[SHIFT +: QW];
    end
    if (f_ready && e_valid_q) begin
      f_red_q   <= f_red_d;
      f_green_q <= f_green_d;
      f_blue_q  <= f_blue_d;
    end
  end

  assign out_valid_o = f_valid_q;
  assign red_o       = f_red_q;
  assign green_o     = f_green_q;
  assign blue_o      = f_blue_q;

endmodule

// File: design/hsi_to_rgb_led_drive.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSI to RGB LED drive
// Converts a hue in whole degrees into red, green and blue drive values.
// ----------------------------------------------------------------------------
// Usage:
//   A hue item enters on the s_axis channel (tdata bits 8:0, 360 and above
//   fold back by one turn). One color item leaves on the m_axis channel with
//   red, green and blue drive values packed from the low bits up.
//   Saturation, intensity and output inversion are set through the cfg write
//   port, which the user is to write only while the block is idle; the block
//   does not enforce this. Saturation and intensity clamp to 1.0. There are
//   six register stages between an accepted hue item and its color item: two
//   for sector and ratio lookup, two for the terms and intensity products, two
//   for full-scale scaling, division by three and channel routing.
//   Throughput is one item per cycle while the receiver takes items. Every stage has its own valid bit and
//   loads when it is empty or its successor moves, so bubbles close up and
//   new items are taken while a finished result waits at the output.
//   When the receiver stalls, the full pipeline holds every item in place and
//   s_axis_tready falls only once all six stages are occupied.
//   Reset empties the pipeline and sets saturation and intensity to 1.0 and
//   inversion on (common-anode LEDs).
// ----------------------------------------------------------------------------
module hsi_to_rgb_led_drive #(
  parameter int unsigned CHANNEL_BITS        = hsi2rgb_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned RATIO_FRACTION_BITS = hsi2rgb_pkg::RATIO_FRAC_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Hue items.
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [15:0]                             s_axis_tdata,  // hue_degrees
  // Color items.
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // red_drive, green_drive, blue_drive, zero fill
  output logic [((3*CHANNEL_BITS+7)/8)*8-1:0]     m_axis_tdata,
  // Configuration writes.
  input  logic                                    cfg_we_i,
  input  logic [hsi2rgb_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [hsi2rgb_pkg::CFG_W-1:0]           cfg_wdata_i
);
  import hsi2rgb_pkg::*;

  localparam int unsigned CB     = CHANNEL_BITS;
  localparam int unsigned R      = RATIO_FRACTION_BITS;
  localparam int unsigned PW     = R + 2 * CFG_W + 1;
  localparam int unsigned OUT_W  = ((3 * CHANNEL_BITS + 7) / 8) * 8;
  localparam int unsigned PAD_W  = OUT_W - 3 * CB;

  logic [CFG_W-1:0]     sat_q, sat_d;
  logic [CFG_W-1:0]     int_q, int_d;
  logic                 inv_q, inv_d;
  logic [CFG_W-1:0]     wdata_clamp;

  logic                 sec_valid;
  logic                 sec_ready;
  sector_e              sec_sector;
  logic signed [R+2:0]  sec_ratio;
  logic                 term_valid;
  logic                 term_ready;
  sector_e              term_sector;
  logic [PW-1:0]        term_prim;
  logic [PW-1:0]        term_sec;
  logic [PW-1:0]        term_ter;
  logic [CB-1:0]        red;
  logic [CB-1:0]        green;
  logic [CB-1:0]        blue;

  // Register write decode; levels above 1.0 are clamped on the way in.
  always_comb begin
    wdata_clamp = (cfg_wdata_i > UNIT_Q8) ? UNIT_Q8 : cfg_wdata_i;
    sat_d       = sat_q;
    int_d       = int_q;
    inv_d       = inv_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_SATURATION: sat_d = wdata_clamp;
        CFG_INTENSITY:  int_d = wdata_clamp;
        CFG_INVERT:     inv_d = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= UNIT_Q8;
      int_q <= UNIT_Q8;
      inv_q <= 1'b1;
    end else begin
      sat_q <= sat_d;
      int_q <= int_d;
      inv_q <= inv_d;
    end
  end

  // Sector and ratio lookup.
  hsi2rgb_sector #(
    .RATIO_FRACTION_BITS (R)
  ) u_sector (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .hue_i       (s_axis_tdata[HUE_W-1:0]),
    .out_valid_o (sec_valid),
    .out_ready_i (sec_ready),
    .sector_o    (sec_sector),
    .ratio_o     (sec_ratio)
  );

  // Channel terms times intensity.
  hsi2rgb_terms #(
    .RATIO_FRACTION_BITS (R)
  ) u_terms (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .saturation_i (sat_q),
    .intensity_i  (int_q),
    .in_valid_i   (sec_valid),
    .in_ready_o   (sec_ready),
    .sector_i     (sec_sector),
    .ratio_i      (sec_ratio),
    .out_valid_o  (term_valid),
    .out_ready_i  (term_ready),
    .sector_o     (term_sector),
    .prim_o       (term_prim),
    .sec_o        (term_sec),
    .ter_o        (term_ter)
  );

  // Scaling, saturation, inversion and routing.
  hsi2rgb_scale #(
    .CHANNEL_BITS        (CB),
    .RATIO_FRACTION_BITS (R)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .invert_i    (inv_q),
    .in_valid_i  (term_valid),
    .in_ready_o  (term_ready),
    .sector_i    (term_sector),
    .prim_i      (term_prim),
    .sec_i       (term_sec),
    .ter_i       (term_ter),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .red_o       (red),
    .green_o     (green),
    .blue_o      (blue)
  );

  assign m_axis_tdata = OUT_W'({blue, green, red});

  // Fill bits stay zero through the size cast above.
  if (PAD_W > 0) begin : g_pad_check
  end

endmodule
